// ===== rtl/rqd_pkg.sv =====
package rqd_pkg;

	localparam int DEPTH_DEF         = 64;
	localparam int HANDLE_BITS_DEF   = 16;
	localparam int PERIOD_W          = 8;
	localparam int CNT_W             = 7;
	localparam int MAX_RESULTS       = 64;
	localparam logic [PERIOD_W-1:0] MISS_PERIOD_RESET = 8'd61;

	typedef enum logic [1:0] {
		CMD_PUSH_BACK  = 2'd0,
		CMD_PUSH_FRONT = 2'd1,
		CMD_TRY_POP    = 2'd2,
		CMD_POP_MANY   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK     = 2'd0,
		STS_EMPTY  = 2'd1,
		STS_MISSED = 2'd2,
		STS_FULL   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_EXEC = 2'd1,
		ST_READ = 2'd2,
		ST_EMIT = 2'd3
	} state_t;

	typedef struct packed {
		logic    capture;
		logic    push_wr;
		logic    attempt_inc;
		logic    miss_clr;
		logic    load_rem;
		logic    rd;
		logic    take;
		logic    emit;
		logic    emit_use_rdata;
		logic    emit_last;
		status_t emit_status;
	} dp_cmd_t;

	typedef struct packed {
		logic is_push;
		logic is_try;
		logic full;
		logic none;
		logic miss;
		logic rem_one;
		logic out_free;
	} dp_sts_t;

endpackage

// ===== rtl/rqd_ctrl.sv =====
module rqd_ctrl
	import rqd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.is_push || sts.none || (sts.is_try && sts.miss)) begin
					if (sts.out_free) begin
						state_d = ST_IDLE;
					end
				end else begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					state_d = sts.rem_one ? ST_IDLE : ST_READ;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.emit_status = STS_OK;
		in_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				cmd.capture = in_valid;
			end
			ST_EXEC: begin
				if (sts.is_push) begin
					cmd.emit        = sts.out_free;
					cmd.push_wr     = sts.out_free && !sts.full;
					cmd.emit_last   = 1'b1;
					cmd.emit_status = sts.full ? STS_FULL : STS_OK;
				end else if (sts.none) begin
					cmd.emit        = sts.out_free;
					cmd.emit_last   = 1'b1;
					cmd.emit_status = STS_EMPTY;
				end else if (sts.is_try && sts.miss) begin
					cmd.emit        = sts.out_free;
					cmd.miss_clr    = sts.out_free;
					cmd.emit_last   = 1'b1;
					cmd.emit_status = STS_MISSED;
				end else begin
					cmd.attempt_inc = sts.is_try;
					cmd.load_rem    = 1'b1;
				end
			end
			ST_READ: begin
				cmd.rd = 1'b1;
			end
			ST_EMIT: begin
				cmd.emit           = sts.out_free;
				cmd.take           = sts.out_free;
				cmd.emit_use_rdata = 1'b1;
				cmd.emit_last      = sts.rem_one;
				cmd.emit_status    = STS_OK;
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/rqd_dp.sv =====
module rqd_dp
	import rqd_pkg::*;
#(
	parameter int DEPTH       = DEPTH_DEF,
	parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [1:0]             cmd,
	input  logic [HANDLE_BITS-1:0] task_handle,
	input  logic [CNT_W-1:0]       pop_count,
	input  logic                   cfg_wr_en,
	input  logic [PERIOD_W-1:0]    cfg_wr_data,
	input  dp_cmd_t                dcmd,
	output dp_sts_t                sts,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             status,
	output logic [HANDLE_BITS-1:0] popped_handle,
	output logic                   last
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;
	localparam int NW = (CW > CNT_W) ? CW : CNT_W;

	logic [HANDLE_BITS-1:0] slots [DEPTH];
	logic [HANDLE_BITS-1:0] rdata_q;

	cmd_t                   cmd_q;
	logic [HANDLE_BITS-1:0] handle_q;
	logic [CNT_W-1:0]       want_q;
	logic [AW-1:0]          front_q;
	logic [CW-1:0]          occ_q;
	logic [PERIOD_W-1:0]    attempts_q;
	logic [PERIOD_W-1:0]    miss_period_q;
	logic [CNT_W-1:0]       rem_q;
	logic                   out_valid_q;
	status_t                status_q;
	logic [HANDLE_BITS-1:0] handle_out_q;
	logic                   last_q;

	logic [SW-1:0]       rear_sum;
	logic [AW-1:0]       rear_idx;
	logic [AW-1:0]       front_dec;
	logic [AW-1:0]       front_inc;
	logic [AW-1:0]       wr_addr;
	logic [NW-1:0]       want_x;
	logic [NW-1:0]       occ_x;
	logic [NW-1:0]       n_clip;
	logic [PERIOD_W-1:0] attempts_nx;
	logic                full;
	logic                out_free;

	always_comb begin
		rear_sum = SW'(front_q) + SW'(occ_q);
		if (rear_sum >= SW'(DEPTH)) begin
			rear_sum = rear_sum - SW'(DEPTH);
		end
		rear_idx  = rear_sum[AW-1:0];
		front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
		front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);
		wr_addr   = (cmd_q == CMD_PUSH_FRONT) ? front_dec : rear_idx;
	end

	always_comb begin
		want_x = NW'(want_q);
		occ_x  = NW'(occ_q);
		n_clip = (want_x < occ_x) ? want_x : occ_x;
		if (n_clip > NW'(MAX_RESULTS)) begin
			n_clip = NW'(MAX_RESULTS);
		end
	end

	assign attempts_nx = attempts_q + PERIOD_W'(1);
	assign full        = (occ_q == CW'(DEPTH));
	assign out_free    = !out_valid_q || !out_stall;

	always_comb begin
		sts.is_push  = (cmd_q == CMD_PUSH_BACK) || (cmd_q == CMD_PUSH_FRONT);
		sts.is_try   = (cmd_q == CMD_TRY_POP);
		sts.full     = full;
		sts.none     = (cmd_q == CMD_TRY_POP) ? (occ_q == '0) : (n_clip == '0);
		sts.miss     = (attempts_nx >= miss_period_q);
		sts.rem_one  = (rem_q == CNT_W'(1));
		sts.out_free = out_free;
	end

	always_ff @(posedge clk) begin
		if (dcmd.push_wr) begin
			slots[wr_addr] <= handle_q;
		end
		if (dcmd.rd) begin
			rdata_q <= slots[front_q];
		end
	end

	always_ff @(posedge clk) begin
		if (dcmd.capture) begin
			cmd_q    <= cmd_t'(cmd);
			handle_q <= task_handle;
			want_q   <= pop_count;
		end
		if (dcmd.emit) begin
			status_q     <= dcmd.emit_status;
			handle_out_q <= dcmd.emit_use_rdata ? rdata_q : '0;
			last_q       <= dcmd.emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q       <= '0;
			occ_q         <= '0;
			attempts_q    <= '0;
			miss_period_q <= MISS_PERIOD_RESET;
			rem_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				miss_period_q <= cfg_wr_data;
			end
			if (dcmd.push_wr) begin
				occ_q <= occ_q + CW'(1);
				if (cmd_q == CMD_PUSH_FRONT) begin
					front_q <= front_dec;
				end
			end else if (dcmd.take) begin
				occ_q   <= occ_q - CW'(1);
				front_q <= front_inc;
			end
			if (dcmd.miss_clr) begin
				attempts_q <= '0;
			end else if (dcmd.attempt_inc) begin
				attempts_q <= attempts_nx;
			end
			if (dcmd.load_rem) begin
				rem_q <= (cmd_q == CMD_TRY_POP) ? CNT_W'(1) : n_clip[CNT_W-1:0];
			end else if (dcmd.take) begin
				rem_q <= rem_q - CNT_W'(1);
			end
			if (dcmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign popped_handle = handle_out_q;
	assign last          = last_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(DEPTH))
		else $error("occupancy beyond ring depth");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		dcmd.push_wr |-> !full)
		else $error("slot written while ring full");

	a_take_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		dcmd.take |-> (occ_q != '0) && (rem_q != '0))
		else $error("take with empty ring or no beats left");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		dcmd.emit |-> out_free)
		else $error("result beat overwritten while stalled");

endmodule

// ===== rtl/run_queue_deque_with_fairness_skip_top.sv =====
// Push: the result beat is registered from the execute state once the input beat is accepted.
// Try pop: empty or missed results come from the execute state; a taken entry goes through read and emit.
// Pop many: each handle passes through a read state and then an emit state, paced by the
// registered read of the single-port slot memory.
// One item at a time; the next input beat is taken once the last result is registered.
// Reset clears front, occupancy and attempt count, loads miss_period with 61; slots keep content.
module run_queue_deque_with_fairness_skip_top
	import rqd_pkg::*;
#(
	parameter int DEPTH       = DEPTH_DEF,
	parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             cmd,
	input  logic [HANDLE_BITS-1:0] task_handle,
	input  logic [CNT_W-1:0]       pop_count,
	input  logic                   cfg_wr_en,
	input  logic [PERIOD_W-1:0]    cfg_wr_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             status,
	output logic [HANDLE_BITS-1:0] popped_handle,
	output logic                   last
);

	dp_cmd_t dcmd;
	dp_sts_t sts;

	rqd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (dcmd)
	);

	rqd_dp #(
		.DEPTH       (DEPTH),
		.HANDLE_BITS (HANDLE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.task_handle   (task_handle),
		.pop_count     (pop_count),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.dcmd          (dcmd),
		.sts           (sts),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.popped_handle (popped_handle),
		.last          (last)
	);

endmodule

// ===== test/run_queue_deque_with_fairness_skip_top_tb.sv =====
module run_queue_deque_with_fairness_skip_top_tb
	import rqd_pkg::*;
;

	localparam int HB = HANDLE_BITS_DEF;
	localparam int RING_AW = $clog2(DEPTH_DEF);

	typedef struct packed {
		status_t       st;
		logic [HB-1:0] handle;
		logic          fin;
	} runq_result_t;

	class runq_scoreboard;
		logic [HB-1:0]      ring [DEPTH_DEF];
		logic [RING_AW-1:0] head;
		int unsigned        held;
		logic [7:0]         attempts;
		logic [7:0]         miss_period;
		runq_result_t       pending [$];
		int unsigned        errors;

		function new();
			head        = '0;
			held        = 0;
			attempts    = '0;
			miss_period = MISS_PERIOD_RESET;
			errors      = 0;
		endfunction

		function void add(status_t st, logic [HB-1:0] h, logic fin);
			runq_result_t r;
			r.st     = st;
			r.handle = h;
			r.fin    = fin;
			pending.push_back(r);
		endfunction

		function logic [HB-1:0] take_front();
			logic [HB-1:0] h;
			h    = ring[head];
			head = head + 1'b1;
			held--;
			return h;
		endfunction

		function void note_request(cmd_t c, logic [HB-1:0] h, logic [CNT_W-1:0] want);
			logic [RING_AW-1:0] idx;
			int unsigned        n;
			case (c)
				CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
					if (held >= DEPTH_DEF) begin
						add(STS_FULL, '0, 1'b1);
					end else begin
						if (c == CMD_PUSH_BACK) begin
							idx = RING_AW'(head + held);
							ring[idx] = h;
						end else begin
							head = head - 1'b1;
							ring[head] = h;
						end
						held++;
						add(STS_OK, '0, 1'b1);
					end
				end
				CMD_TRY_POP: begin
					if (held == 0) begin
						add(STS_EMPTY, '0, 1'b1);
					end else begin
						attempts = attempts + 1'b1;
						if (attempts >= miss_period) begin
							attempts = '0;
							add(STS_MISSED, '0, 1'b1);
						end else begin
							add(STS_OK, take_front(), 1'b1);
						end
					end
				end
				default: begin
					n = 32'(want);
					if (n > held)
						n = held;
					if (n > MAX_RESULTS)
						n = MAX_RESULTS;
					if (n == 0)
						add(STS_EMPTY, '0, 1'b1);
					for (int k = 0; k < n; k++)
						add(STS_OK, take_front(), k == n - 1);
				end
			endcase
		endfunction

		function void check_result(logic [1:0] st, logic [HB-1:0] h, logic fin);
			runq_result_t want_r;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result beat: status %0d handle %h last %b", st, h, fin);
			end else begin
				want_r = pending.pop_front();
				if (want_r.st !== st || want_r.handle !== h || want_r.fin !== fin) begin
					errors++;
					if (errors <= 10)
						$display("bad result beat: expected status %s handle %h last %b, got %0d %h %b",
							want_r.st.name(), want_r.handle, want_r.fin, st, h, fin);
				end
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         cmd = CMD_PUSH_BACK;
	logic [HB-1:0]      task_handle = '0;
	logic [CNT_W-1:0]   pop_count = '0;
	logic               cfg_wr_en = 1'b0;
	logic [PERIOD_W-1:0] cfg_wr_data = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         status;
	logic [HB-1:0]      popped_handle;
	logic               last;

	runq_scoreboard sb = new();

	bit          tx_idle = 1'b0;
	bit          rx_idle = 1'b0;
	logic        hold_req = 1'b0;
	bit          hold_done = 1'b0;
	int unsigned hold_left = 0;
	int unsigned rx_left = 0;
	int unsigned sent = 0;

	run_queue_deque_with_fairness_skip_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.task_handle  (task_handle),
		.pop_count    (pop_count),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.popped_handle(popped_handle),
		.last         (last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(status, popped_handle, last);
		if (hold_req && !hold_done) begin
			hold_done = 1'b1;
			hold_left = 400;
			rx_left = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (!rx_idle) begin
			out_stall <= 1'b0;
		end else if (rx_left > 0) begin
			rx_left--;
		end else if ($urandom_range(0, 99) < 55) begin
			rx_left = $urandom_range(0, 7);
			out_stall <= 1'b0;
		end else begin
			rx_left = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2) : $urandom_range(20, 60);
			out_stall <= 1'b1;
		end
	end

	task automatic send_item(cmd_t c, logic [HB-1:0] h, logic [CNT_W-1:0] n);
		int unsigned gap;
		int unsigned r;
		in_valid    <= 1'b1;
		cmd         <= c;
		task_handle <= h;
		pop_count   <= n;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_request(c, h, n);
		sent++;
		gap = 0;
		if (tx_idle) begin
			r = $urandom_range(0, 99);
			if (r >= 90)
				gap = $urandom_range(10, 40);
			else if (r >= 60)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_period(logic [PERIOD_W-1:0] v);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.miss_period = v;
	endtask

	task automatic run_phase(int unsigned quota);
		int unsigned stop_at;
		int unsigned pick;
		int unsigned k;
		stop_at = sent + quota;
		while (sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				repeat ($urandom_range(1, 12))
					send_item($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK,
						HB'($urandom), CNT_W'($urandom));
			end else if (pick < 47) begin
				repeat ($urandom_range(1, 8))
					send_item(CMD_TRY_POP, HB'($urandom), CNT_W'($urandom));
			end else if (pick < 68) begin
				k = $urandom_range(0, 99);
				send_item(CMD_POP_MANY, HB'($urandom),
					k < 60 ? CNT_W'($urandom_range(1, 8)) :
					k < 85 ? CNT_W'($urandom_range(0, 64)) :
					k < 95 ? CNT_W'($urandom_range(65, 127)) : CNT_W'(0));
			end else if (pick < 72) begin
				// fill the ring, then overflow it
				while (sb.held < DEPTH_DEF)
					send_item($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK,
						HB'($urandom), CNT_W'($urandom));
				repeat ($urandom_range(1, 3))
					send_item($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK,
						HB'($urandom), CNT_W'($urandom));
			end else begin
				send_item(cmd_t'($urandom_range(0, 3)), HB'($urandom), CNT_W'($urandom));
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle = 1'b1;
		rx_idle = 1'b1;
		send_item(CMD_TRY_POP, 16'hffff, 7'h7f);
		send_item(CMD_POP_MANY, 16'h0000, 7'd64);
		send_item(CMD_PUSH_BACK, 16'h0000, 7'h00);
		send_item(CMD_PUSH_BACK, 16'hffff, 7'h7f);
		send_item(CMD_PUSH_FRONT, 16'ha5a5, 7'h2a);
		send_item(CMD_PUSH_FRONT, 16'h5a5a, 7'h55);
		send_item(CMD_POP_MANY, 16'hffff, 7'd0);
		send_item(CMD_TRY_POP, 16'h0000, 7'd0);
		send_item(CMD_POP_MANY, 16'h0000, 7'd1);
		send_item(CMD_PUSH_BACK, 16'h1234, 7'd0);
		send_item(CMD_PUSH_FRONT, 16'h8001, 7'd0);
		send_item(CMD_POP_MANY, 16'h0000, 7'd127);
		send_item(CMD_TRY_POP, 16'h0000, 7'd0);

		set_period(8'd1);
		send_item(CMD_PUSH_BACK, 16'h0f0f, 7'd0);
		send_item(CMD_PUSH_BACK, 16'hf0f0, 7'd0);
		send_item(CMD_TRY_POP, 16'h0000, 7'd0);
		send_item(CMD_TRY_POP, 16'h0000, 7'd0);

		set_period(8'd0);
		send_item(CMD_TRY_POP, 16'h0000, 7'd0);

		// build up the attempt count, then lower the period below it
		set_period(8'd255);
		send_item(CMD_TRY_POP, 16'h0000, 7'd0);
		send_item(CMD_TRY_POP, 16'h0000, 7'd0);
		send_item(CMD_PUSH_BACK, 16'h0001, 7'd0);
		send_item(CMD_PUSH_BACK, 16'h8000, 7'd0);
		send_item(CMD_PUSH_BACK, 16'h7fff, 7'd0);
		send_item(CMD_TRY_POP, 16'h0000, 7'd0);
		set_period(8'd2);
		send_item(CMD_TRY_POP, 16'h0000, 7'd0);
		send_item(CMD_POP_MANY, 16'h0000, 7'd64);

		set_period(MISS_PERIOD_RESET);
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		run_phase(100);

		set_period(8'd255);
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		run_phase(50);
		hold_req <= 1'b1;
		tx_idle = 1'b0;
		run_phase(30);
		tx_idle = 1'b1;
		run_phase(20);

		set_period(PERIOD_W'($urandom_range(2, 9)));
		run_phase(50);
		drain();
		run_phase(50);

		set_period(8'd1);
		run_phase(60);

		set_period(PERIOD_W'($urandom_range(1, 255)));
		run_phase(140);

		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#40000000;
		$display("Mismatches found");
		$finish;
	end

endmodule
